[design/nmea_sentence_framer_macros.svh]
// Assertion macros for the NMEA sentence framer.
// Expect a clock named clk and an active-low reset named rst_n in the using module.
`ifndef NMEA_SENTENCE_FRAMER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSF_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("nsf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NSF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("nsf: next-cycle check failed");

`endif

[design/nsf_pkg.sv]
// Shared types and constants for the NMEA sentence framer.
// No dependencies.
package nsf_pkg;

  localparam int unsigned MAX_SENTENCE     = 128;
  localparam int unsigned MAX_CHECK_DIGITS = 2;

  localparam logic [7:0] SYM_START = 8'h24;
  localparam logic [7:0] SYM_STAR  = 8'h2a;
  localparam logic [7:0] SYM_CR    = 8'h0d;
  localparam logic [7:0] SYM_LF    = 8'h0a;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CSUM = 2'd2,
    PH_WLF  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ERROR = 2'd1,
    ST_DONE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RESTART  = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_MISMATCH = 3'd3,
    ERR_CSUM_OVF = 3'd4,
    ERR_NO_LF    = 3'd5
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  length_count;
    logic [7:0]  running_xor;
    logic [15:0] checksum_value;
    logic [2:0]  checksum_digits;
    logic        hex_stopped;
  } frame_state_t;

  typedef struct packed {
    status_t    status;
    err_t       error_kind;
    logic [7:0] sentence_length;
    logic [7:0] body_byte;
    logic       body_valid;
    logic       body_restart;
  } frame_result_t;

endpackage

[design/nsf_step.sv]
// Next-state and result logic for one received byte of the sentence framer.
// Depends on nsf_pkg.
module nsf_step #(
  parameter int unsigned MAX_SENTENCE     = nsf_pkg::MAX_SENTENCE,
  parameter int unsigned MAX_CHECK_DIGITS = nsf_pkg::MAX_CHECK_DIGITS
) (
  input  nsf_pkg::frame_state_t  state_i,
  input  logic [7:0]             byte_i,
  output nsf_pkg::frame_state_t  state_o,
  output nsf_pkg::frame_result_t result_o
);

  logic       hex_ok;
  logic [3:0] hex_digit;

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    case (byte_i) inside
      [8'h30:8'h39]: hex_digit = 4'(byte_i - 8'h30);
      [8'h41:8'h46]: hex_digit = 4'(byte_i - 8'h41 + 8'd10);
      [8'h61:8'h66]: hex_digit = 4'(byte_i - 8'h61 + 8'd10);
      default:       hex_ok    = 1'b0;
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{status: nsf_pkg::ST_NONE, error_kind: nsf_pkg::ERR_NONE,
                 sentence_length: 8'd0, body_byte: 8'd0,
                 body_valid: 1'b0, body_restart: 1'b0};
    case (state_i.phase)
      nsf_pkg::PH_IDLE: begin
        if (byte_i == nsf_pkg::SYM_START) begin
          state_o.phase        = nsf_pkg::PH_BODY;
          state_o.length_count = 8'd1;
          state_o.running_xor  = 8'd0;
          result_o.body_byte    = byte_i;
          result_o.body_valid   = 1'b1;
          result_o.body_restart = 1'b1;
        end
      end
      nsf_pkg::PH_BODY, nsf_pkg::PH_CSUM: begin
        if (byte_i == nsf_pkg::SYM_START) begin
          // restart the store with this '$'
          state_o.phase        = nsf_pkg::PH_BODY;
          state_o.length_count = 8'd1;
          state_o.running_xor  = 8'd0;
          result_o.body_byte    = byte_i;
          result_o.body_valid   = 1'b1;
          result_o.body_restart = 1'b1;
          result_o.status       = nsf_pkg::ST_ERROR;
          result_o.error_kind   = nsf_pkg::ERR_RESTART;
        end else if (state_i.phase == nsf_pkg::PH_BODY) begin
          if (byte_i == nsf_pkg::SYM_STAR) begin
            state_o.phase           = nsf_pkg::PH_CSUM;
            state_o.checksum_value  = 16'd0;
            state_o.checksum_digits = 3'd0;
            state_o.hex_stopped     = 1'b0;
          end else if (state_i.length_count >= 8'(MAX_SENTENCE)) begin
            state_o.phase       = nsf_pkg::PH_IDLE;
            result_o.status     = nsf_pkg::ST_ERROR;
            result_o.error_kind = nsf_pkg::ERR_OVERFLOW;
          end else begin
            state_o.length_count = state_i.length_count + 8'd1;
            state_o.running_xor  = state_i.running_xor ^ byte_i;
            result_o.body_byte   = byte_i;
            result_o.body_valid  = 1'b1;
          end
        end else begin
          if (byte_i == nsf_pkg::SYM_CR) begin
            if (state_i.checksum_value != {8'd0, state_i.running_xor}) begin
              state_o.phase       = nsf_pkg::PH_IDLE;
              result_o.status     = nsf_pkg::ST_ERROR;
              result_o.error_kind = nsf_pkg::ERR_MISMATCH;
            end else begin
              state_o.phase = nsf_pkg::PH_WLF;
            end
          end else if (state_i.checksum_digits >= 3'(MAX_CHECK_DIGITS)) begin
            state_o.phase       = nsf_pkg::PH_IDLE;
            result_o.status     = nsf_pkg::ST_ERROR;
            result_o.error_kind = nsf_pkg::ERR_CSUM_OVF;
          end else begin
            state_o.checksum_digits = state_i.checksum_digits + 3'd1;
            // freeze the value at the first non-hex character
            if (!state_i.hex_stopped) begin
              if (!hex_ok) begin
                state_o.hex_stopped = 1'b1;
              end else begin
                state_o.checksum_value = {state_i.checksum_value[11:0], hex_digit};
              end
            end
          end
        end
      end
      default: begin
        if (byte_i == nsf_pkg::SYM_LF) begin
          state_o.phase            = nsf_pkg::PH_IDLE;
          result_o.status          = nsf_pkg::ST_DONE;
          result_o.sentence_length = state_i.length_count;
        end else begin
          result_o.status     = nsf_pkg::ST_ERROR;
          result_o.error_kind = nsf_pkg::ERR_NO_LF;
        end
      end
    endcase
  end

endmodule

[design/nsf_out_stage.sv]
// Result register of the sentence framer with valid/stall handshake.
// Depends on nsf_pkg.
module nsf_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  nsf_pkg::frame_result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid,
  input  logic                   out_stall,
  output nsf_pkg::frame_result_t result_o
);

  logic                   valid_r;
  logic                   valid_nxt;
  nsf_pkg::frame_result_t result_r;

  // free when empty or when the held request leaves this cycle
  assign ready_o   = !valid_r || !out_stall;
  assign valid_nxt = load_i ? 1'b1 : (ready_o ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = result_r;

endmodule

[design/nmea_sentence_framer.sv]
// Top level of the NMEA sentence framer: input register, framing state, result stage.
// Depends on nsf_pkg, nsf_step, nsf_out_stage and nmea_sentence_framer_macros.svh.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_data_byte
//   out_    | output    | out_valid/out_stall | out_status, out_error_kind,
//           |           |                     | out_sentence_length, out_body_*
//
// One byte enters per cycle while in_stall is low; each request gives one result
// after it is taken, passing through the input register, then the result register.
// The framing state updates as the byte moves from the input register into
// the result register, so one short logic level sets the clock.
// Reset (rst_n low at a clock edge) empties both registers and returns to idle.
// A stall on the output holds the result and backs up into in_stall.
`include "nmea_sentence_framer_macros.svh"

module nmea_sentence_framer #(
  parameter int unsigned MAX_SENTENCE     = nsf_pkg::MAX_SENTENCE,
  parameter int unsigned MAX_CHECK_DIGITS = nsf_pkg::MAX_CHECK_DIGITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [2:0] out_error_kind,
  output logic [7:0] out_sentence_length,
  output logic [7:0] out_body_byte,
  output logic       out_body_valid,
  output logic       out_body_restart
);

  logic                   in_valid_r;
  logic                   in_valid_nxt;
  logic [7:0]             in_byte_r;
  logic                   in_take;
  logic                   out_ready;
  logic                   fire;
  nsf_pkg::frame_state_t  state_r;
  nsf_pkg::frame_state_t  state_nxt;
  nsf_pkg::frame_result_t step_result;
  nsf_pkg::frame_result_t out_result;

  assign fire         = in_valid_r && out_ready;
  assign in_stall     = in_valid_r && !fire;
  assign in_take      = in_valid && !in_stall;
  assign in_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
  end

  nsf_step #(
    .MAX_SENTENCE     (MAX_SENTENCE),
    .MAX_CHECK_DIGITS (MAX_CHECK_DIGITS)
  ) u_step (
    .state_i  (state_r),
    .byte_i   (in_byte_r),
    .state_o  (state_nxt),
    .result_o (step_result)
  );

  // advance the framing state only when the byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: nsf_pkg::PH_IDLE, length_count: 8'd0, running_xor: 8'd0,
                   checksum_value: 16'd0, checksum_digits: 3'd0, hex_stopped: 1'b0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  nsf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (fire),
    .result_i  (step_result),
    .ready_o   (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_o  (out_result)
  );

  assign out_status          = out_result.status;
  assign out_error_kind      = out_result.error_kind;
  assign out_sentence_length = out_result.sentence_length;
  assign out_body_byte       = out_result.body_byte;
  assign out_body_valid      = out_result.body_valid;
  assign out_body_restart    = out_result.body_restart;

  `NSF_ASSERT_NOW(a_err_only_on_error,
    out_valid && out_status != nsf_pkg::ST_ERROR, out_error_kind == nsf_pkg::ERR_NONE)
  `NSF_ASSERT_NOW(a_restart_is_start,
    out_valid && out_body_restart, out_body_valid && out_body_byte == nsf_pkg::SYM_START)
  `NSF_ASSERT_NOW(a_done_has_length,
    out_valid && out_status == nsf_pkg::ST_DONE, out_sentence_length != 8'd0 && !out_body_valid)
  `NSF_ASSERT_NEXT(a_held_byte_stays,
    in_valid_r && !fire, in_valid_r && $stable(in_byte_r))
  `NSF_ASSERT_NOW(a_length_bounded,
    state_r.phase != nsf_pkg::PH_IDLE, state_r.length_count <= 8'(MAX_SENTENCE))

endmodule
